FILE: sv/bev_pkg.sv
// Shared types, constants and a helper function for the button event auto-repeat block.
package bev_pkg;

  // Widths fixed by the fields of the interface.
  localparam int MASK_W    = 8;
  localparam int KEY_W     = 3;
  localparam int KIND_W    = 2;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Reset values of the timing registers and of the hold countdowns.
  localparam logic [CNT_W-1:0] DELAY_RESET  = 8'd10;
  localparam logic [CNT_W-1:0] REPEAT_RESET = 8'd4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_INIT_DELAY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;

  // Event kind codes.
  localparam logic [KIND_W-1:0] KIND_UP    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DOWN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRESS = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_EMIT
  } state_t;

  // Result of one pass through the countdown unit.
  typedef struct packed {
    logic             wen;
    logic             rpt_due;
    logic [CNT_W-1:0] next_cd;
  } cd_upd_t;

  // A timing register that holds zero behaves as one.
  function automatic logic [CNT_W-1:0] load_value(input logic [CNT_W-1:0] reg_val);
    load_value = (reg_val == '0) ? CNT_W'(1) : reg_val;
  endfunction

endpackage

FILE: sv/bev_cd_unit.sv
// Shared countdown unit: decrement, initial load, repeat detection and reload for one button.
module bev_cd_unit (
  input  logic [bev_pkg::CNT_W-1:0] cd,
  input  logic                      held,
  input  logic                      pressed,
  input  logic [bev_pkg::CNT_W-1:0] init_ticks,
  input  logic [bev_pkg::CNT_W-1:0] repeat_ticks,
  output bev_pkg::cd_upd_t          upd
);

  logic [bev_pkg::CNT_W-1:0] dec_cd;
  logic [bev_pkg::CNT_W-1:0] loaded_cd;
  logic                      rpt;

  // A held button counts down; a new press loads the initial delay.
  always_comb begin
    dec_cd    = (held && (cd != '0)) ? (cd - bev_pkg::CNT_W'(1)) : cd;
    loaded_cd = pressed ? bev_pkg::load_value(init_ticks) : dec_cd;
    rpt       = (loaded_cd == '0);
  end

  // An expired countdown fires a repeat and reloads with the repeat interval.
  always_comb begin
    upd.rpt_due = rpt;
    upd.next_cd = rpt ? bev_pkg::load_value(repeat_ticks) : loaded_cd;
    upd.wen     = held || pressed || rpt;
  end

endmodule

FILE: sv/bev_cd_bank.sv
// Hold countdown storage for all buttons, with a per-button flag for a repeat due next tick.
module bev_cd_bank #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [IDX_W-1:0]          rd_idx,
  output logic [bev_pkg::CNT_W-1:0] rd_cd,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [bev_pkg::CNT_W-1:0] wr_cd,
  output logic [DEPTH-1:0]          due
);

  logic [bev_pkg::CNT_W-1:0] cd_r [DEPTH];
  logic [DEPTH-1:0]          due_r;

  // Countdowns start at the reset delay; a countdown of one expires on the next held tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        cd_r[i] <= bev_pkg::DELAY_RESET;
      end
      due_r <= '0;
    end else if (wr_en) begin
      cd_r[wr_idx]  <= wr_cd;
      due_r[wr_idx] <= (wr_cd == bev_pkg::CNT_W'(1));
    end
  end

  assign rd_cd = cd_r[rd_idx];
  assign due   = due_r;

  // A written countdown is never left at zero.
  a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> cd_r[$past(wr_idx)] != '0)
    else $error("countdown written as zero");

  // The due flag tracks the stored countdown.
  a_due_match: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> due_r[$past(wr_idx)] == (cd_r[$past(wr_idx)] == bev_pkg::CNT_W'(1)))
    else $error("due flag out of step with countdown");

endmodule

FILE: sv/button_event_autorepeat_unit.sv
// Top level: tick acceptance, button sequencer, configuration registers and result register.
// The first event of a tick passes the step and emit states before it is registered on
// the output, after a step through each quiet button ahead of the first that emits.
// A tick holds the block in the step state once per active button and in the emit state
// once per event, and a new tick is accepted only back in idle; the emit state waits
// while the output is stalled. Buttons share the single countdown unit.
// Reset: timing registers to 10 and 4, previous mask to zero, all countdowns to 10.
module button_event_autorepeat_unit #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bev_pkg::MASK_W-1:0]    in_button_mask,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bev_pkg::KEY_W-1:0]     out_key_index,
  output logic [bev_pkg::KIND_W-1:0]    out_event_kind,
  output logic                          out_last_event,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bev_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bev_pkg::CNT_W-1:0]     cfg_data
);

  // Buttons beyond the mask width never change and never emit.
  localparam int ACTIVE = (NUM_BUTTONS < bev_pkg::MASK_W) ? NUM_BUTTONS : bev_pkg::MASK_W;
  localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ACTIVE - 1);

  bev_pkg::state_t state_r, state_nxt;

  logic [bev_pkg::CNT_W-1:0]  init_r, rep_r;
  logic [bev_pkg::MASK_W-1:0] prev_r;
  logic [ACTIVE-1:0]          rel_r, prs_r, held_r, pend_r;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [bev_pkg::KIND_W-1:0] k0_r, k0_nxt, k1_r, k1_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       sel_r, sel_nxt;

  logic                       out_valid_r;
  logic [bev_pkg::KEY_W-1:0]  out_key_r;
  logic [bev_pkg::KIND_W-1:0] out_kind_r;
  logic                       out_last_r;

  logic                      in_fire, out_fire, out_free;
  logic [ACTIVE-1:0]         now_v, prev_v, due_v;
  logic [bev_pkg::CNT_W-1:0] rd_cd;
  bev_pkg::cd_upd_t          upd;
  logic                      rest_any, button_done, load_out, cd_wen, at_last;

  assign in_ready  = (state_r == bev_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign now_v  = in_button_mask[ACTIVE-1:0];
  assign prev_v = prev_r[ACTIVE-1:0];

  // Countdown storage and the shared countdown unit.
  bev_cd_bank #(
    .DEPTH(ACTIVE),
    .IDX_W(IDX_W)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_idx(idx_r),
    .rd_cd (rd_cd),
    .wr_en (cd_wen),
    .wr_idx(idx_r),
    .wr_cd (upd.next_cd),
    .due   (due_v)
  );

  bev_cd_unit u_unit (
    .cd          (rd_cd),
    .held        (held_r[idx_r]),
    .pressed     (prs_r[idx_r]),
    .init_ticks  (init_r),
    .repeat_ticks(rep_r),
    .upd         (upd)
  );

  // Any button above the current one still has events for this tick.
  always_comb begin
    rest_any = 1'b0;
    for (int j = 0; j < ACTIVE; j++) begin
      if (pend_r[j] && (IDX_W'(j) > idx_r)) begin
        rest_any = 1'b1;
      end
    end
  end

  assign button_done = (cnt_r == 2'd1) || sel_r;
  assign at_last     = (idx_r == LAST_IDX);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bev_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = bev_pkg::ST_STEP;
        end
      end
      bev_pkg::ST_STEP: begin
        if (rel_r[idx_r] || prs_r[idx_r] || upd.rpt_due) begin
          state_nxt = bev_pkg::ST_EMIT;
        end else if (at_last) begin
          state_nxt = bev_pkg::ST_IDLE;
        end
      end
      bev_pkg::ST_EMIT: begin
        if (out_free && button_done) begin
          state_nxt = at_last ? bev_pkg::ST_IDLE : bev_pkg::ST_STEP;
        end
      end
      default: state_nxt = bev_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: button index, event slots and strobes.
  always_comb begin
    idx_nxt  = idx_r;
    k0_nxt   = k0_r;
    k1_nxt   = k1_r;
    cnt_nxt  = cnt_r;
    sel_nxt  = sel_r;
    load_out = 1'b0;
    cd_wen   = 1'b0;
    case (state_r)
      bev_pkg::ST_IDLE: begin
        if (in_fire) begin
          idx_nxt = '0;
        end
      end
      bev_pkg::ST_STEP: begin
        cd_wen  = upd.wen;
        sel_nxt = 1'b0;
        if (rel_r[idx_r]) begin
          cnt_nxt = 2'd1;
          k0_nxt  = bev_pkg::KIND_UP;
        end else if (prs_r[idx_r]) begin
          cnt_nxt = 2'd2;
          k0_nxt  = bev_pkg::KIND_DOWN;
          k1_nxt  = bev_pkg::KIND_PRESS;
        end else if (upd.rpt_due) begin
          cnt_nxt = 2'd1;
          k0_nxt  = bev_pkg::KIND_PRESS;
        end else begin
          cnt_nxt = 2'd0;
          if (!at_last) begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      bev_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (button_done) begin
            if (!at_last) begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end else begin
            sel_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bev_pkg::ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= 2'd0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      init_r      <= bev_pkg::DELAY_RESET;
      rep_r       <= bev_pkg::REPEAT_RESET;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        prev_r <= in_button_mask;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bev_pkg::REG_INIT_DELAY:      init_r <= cfg_data;
          bev_pkg::REG_REPEAT_INTERVAL: rep_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Edge vectors of the accepted tick and the buttons that will emit.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rel_r  <= prev_v & ~now_v;
      prs_r  <= now_v & ~prev_v;
      held_r <= now_v & prev_v;
      pend_r <= (prev_v & ~now_v) | (now_v & ~prev_v) | (now_v & prev_v & due_v);
    end
  end

  // Event slots and result register payload.
  always_ff @(posedge clk) begin
    k0_r <= k0_nxt;
    k1_r <= k1_nxt;
    if (load_out) begin
      out_key_r  <= bev_pkg::KEY_W'(idx_r);
      out_kind_r <= sel_r ? k1_r : k0_r;
      out_last_r <= button_done && !rest_any;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_index  = out_key_r;
  assign out_event_kind = out_kind_r;
  assign out_last_event = out_last_r;

  // An accepted tick starts its scan at button zero.
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == bev_pkg::ST_STEP) && (idx_r == '0))
    else $error("scan did not start at button zero");

  // Emission only happens with at least one event queued for the button.
  a_emit_has_event: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bev_pkg::ST_EMIT) |-> (cnt_r != 2'd0))
    else $error("emit state with no event queued");

  // A second event of a button only follows a new press.
  a_second_event: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && sel_r) |-> (cnt_r == 2'd2) && (k1_r == bev_pkg::KIND_PRESS))
    else $error("second event without a new press");

endmodule

FILE: bench/tb_button_event_autorepeat_unit.sv
// Self-checking testbench for the button event auto-repeat unit with a typematic predictor.
module tb_button_event_autorepeat_unit;

  localparam int NUM_KEYS            = 8;
  localparam int MAX_EVENTS_PER_TICK = 16;
  localparam int SETTLE_CYCLES       = 40;
  localparam int WATCHDOG_LIMIT      = 3000;
  localparam int TICKS_PER_PHASE     = 25;
  localparam int MAX_REPORTS         = 10;

  // Register indexes that map to no register.
  localparam logic [bev_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [bev_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [bev_pkg::KEY_W-1:0]  key;
    logic [bev_pkg::KIND_W-1:0] kind;
    logic                       last;
  } key_event_t;

  typedef enum logic {
    ROW_TICK,
    ROW_CFG
  } row_op_t;

  // One row of the directed table: a tick or a register write.
  typedef struct packed {
    row_op_t                       op;
    logic [bev_pkg::MASK_W-1:0]    value;
    logic [bev_pkg::CFG_IDX_W-1:0] index;
    logic                          typed;
    logic [1:0]                    n_typed;
    key_event_t                    first_ev;
    key_event_t                    second_ev;
  } directed_row_t;

  localparam key_event_t NO_EVENT = '0;

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic [bev_pkg::MASK_W-1:0]    in_button_mask = '0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [bev_pkg::KEY_W-1:0]     out_key_index;
  logic [bev_pkg::KIND_W-1:0]    out_event_kind;
  logic                          out_last_event;
  logic                          cfg_valid      = 1'b0;
  logic                          cfg_ready;
  logic [bev_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
  logic [bev_pkg::CNT_W-1:0]     cfg_data       = '0;

  // Predictor state: last mask, per-button hold countdowns and timing registers.
  logic [bev_pkg::MASK_W-1:0] prev_buttons;
  logic [bev_pkg::CNT_W-1:0]  hold_count [NUM_KEYS];
  logic [bev_pkg::CNT_W-1:0]  delay_reg;
  logic [bev_pkg::CNT_W-1:0]  interval_reg;

  key_event_t tick_events[$];
  key_event_t typed_events[$];
  key_event_t pending_events[$];

  int fail_count    = 0;
  int idle_cycles   = 0;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  directed_row_t directed_rows [21] = '{
    '{ROW_TICK, 8'h00, bev_pkg::REG_INIT_DELAY, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'h01, bev_pkg::REG_INIT_DELAY, 1'b1, 2'd2,
      '{3'd0, bev_pkg::KIND_DOWN, 1'b0}, '{3'd0, bev_pkg::KIND_PRESS, 1'b1}},
    '{ROW_TICK, 8'h01, bev_pkg::REG_INIT_DELAY, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'h00, bev_pkg::REG_INIT_DELAY, 1'b1, 2'd1,
      '{3'd0, bev_pkg::KIND_UP, 1'b1}, NO_EVENT},
    '{ROW_TICK, 8'hFF, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'h00, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'h80, bev_pkg::REG_INIT_DELAY, 1'b1, 2'd2,
      '{3'd7, bev_pkg::KIND_DOWN, 1'b0}, '{3'd7, bev_pkg::KIND_PRESS, 1'b1}},
    '{ROW_CFG, 8'h00, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_CFG, 8'h00, bev_pkg::REG_REPEAT_INTERVAL, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'h80, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'h81, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'h81, bev_pkg::REG_INIT_DELAY, 1'b1, 2'd1,
      '{3'd0, bev_pkg::KIND_PRESS, 1'b1}, NO_EVENT},
    '{ROW_TICK, 8'h55, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'hAA, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'hAA, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_CFG, 8'hFF, REG_SPARE_A, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_CFG, 8'h00, REG_SPARE_B, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_CFG, 8'hFF, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_CFG, 8'hFF, bev_pkg::REG_REPEAT_INTERVAL, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'hFF, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{ROW_TICK, 8'h00, bev_pkg::REG_INIT_DELAY, 1'b0, 2'd0, NO_EVENT, NO_EVENT}
  };

  button_event_autorepeat_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_button_mask (in_button_mask),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_index  (out_key_index),
    .out_event_kind (out_event_kind),
    .out_last_event (out_last_event),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Clock with a period of 8 time units.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  function automatic void log_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", what);
  endfunction

  // Appends one event of the current tick, dropping any beyond the per-tick limit.
  function automatic void note_event(input int button,
                                     input logic [bev_pkg::KIND_W-1:0] kind);
    if (tick_events.size() < MAX_EVENTS_PER_TICK)
      tick_events.push_back('{key: bev_pkg::KEY_W'(button), kind: kind, last: 1'b0});
  endfunction

  // Typematic step: releases, new presses and due repeats, in button order.
  function automatic void step_keypad(input logic [bev_pkg::MASK_W-1:0] now);
    logic [bev_pkg::MASK_W-1:0] released;
    logic [bev_pkg::MASK_W-1:0] pressed;
    logic [bev_pkg::MASK_W-1:0] held;
    key_event_t                 final_ev;
    tick_events.delete();
    released = prev_buttons & ~now;
    pressed  = now & ~prev_buttons;
    held     = now & prev_buttons;
    for (int b = 0; b < NUM_KEYS; b++) begin
      if (held[b] && hold_count[b] != '0) hold_count[b] = hold_count[b] - 1'b1;
      if (released[b]) note_event(b, bev_pkg::KIND_UP);
      if (pressed[b]) begin
        note_event(b, bev_pkg::KIND_DOWN);
        note_event(b, bev_pkg::KIND_PRESS);
        hold_count[b] = (delay_reg == '0) ? bev_pkg::CNT_W'(1) : delay_reg;
      end
      // A countdown that has run out fires one repeat and restarts.
      if (hold_count[b] == '0) begin
        note_event(b, bev_pkg::KIND_PRESS);
        hold_count[b] = (interval_reg == '0) ? bev_pkg::CNT_W'(1) : interval_reg;
      end
    end
    prev_buttons = now;
    if (tick_events.size() > 0) begin
      final_ev = tick_events.pop_back();
      final_ev.last = 1'b1;
      tick_events.push_back(final_ev);
    end
  endfunction

  // Random masks mostly evolve from the last one so that holds last long enough to repeat.
  function automatic logic [bev_pkg::MASK_W-1:0] next_mask();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return prev_buttons;
    if (pick < 70)
      return prev_buttons ^
             (bev_pkg::MASK_W'(1) << $urandom_range(0, bev_pkg::MASK_W - 1));
    if (pick < 85) return prev_buttons ^ bev_pkg::MASK_W'($urandom_range(0, 255));
    return bev_pkg::MASK_W'($urandom);
  endfunction

  // Sends one tick transaction and queues the events it should cause.
  task automatic send_tick(input logic [bev_pkg::MASK_W-1:0] mask, input logic use_typed);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_button_mask <= mask;
    do @(posedge clk); while (!in_ready);
    step_keypad(mask);
    if (use_typed) begin
      foreach (typed_events[i]) pending_events.push_back(typed_events[i]);
    end else begin
      foreach (tick_events[i]) pending_events.push_back(tick_events[i]);
    end
  endtask

  // Stops sending, waits for every pending event, then lets the block finish its walk.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic [bev_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bev_pkg::CNT_W-1:0] data);
    settle_block();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bev_pkg::REG_INIT_DELAY) delay_reg = data;
    else if (idx == bev_pkg::REG_REPEAT_INTERVAL) interval_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checking and the watchdog on accepted transactions.
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        log_failure($sformatf("unexpected event: key %0d kind %0d last %0d",
                              out_key_index, out_event_kind, out_last_event));
      end else begin
        want = pending_events.pop_front();
        if (want.key !== out_key_index || want.kind !== out_event_kind ||
            want.last !== out_last_event) begin
          log_failure($sformatf(
            "event mismatch: expected key %0d kind %0d last %0d, got key %0d kind %0d last %0d",
            want.key, want.kind, want.last, out_key_index, out_event_kind, out_last_event));
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    directed_row_t             row;
    int                        phase;
    int                        n;
    logic [bev_pkg::CNT_W-1:0] delay_val;
    logic [bev_pkg::CNT_W-1:0] interval_val;

    prev_buttons = '0;
    delay_reg    = bev_pkg::DELAY_RESET;
    interval_reg = bev_pkg::REPEAT_RESET;
    for (int b = 0; b < NUM_KEYS; b++) hold_count[b] = bev_pkg::DELAY_RESET;

    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_CFG) begin
        write_reg(row.index, row.value);
      end else begin
        typed_events.delete();
        if (row.n_typed > 0) typed_events.push_back(row.first_ev);
        if (row.n_typed > 1) typed_events.push_back(row.second_ev);
        send_tick(row.value, row.typed);
      end
    end

    // Random phases, each with its own idling pattern and register setting.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          delay_val    = bev_pkg::CNT_W'($urandom_range(1, 6));
          interval_val = bev_pkg::CNT_W'($urandom_range(1, 4));
        end
        1: begin
          delay_val    = 8'hFF;
          interval_val = 8'hFF;
        end
        2: begin
          delay_val    = 8'h01;
          interval_val = 8'h01;
        end
        default: begin
          delay_val    = bev_pkg::CNT_W'($urandom_range(0, 12));
          interval_val = bev_pkg::CNT_W'($urandom_range(0, 12));
        end
      endcase
      write_reg(bev_pkg::REG_INIT_DELAY, delay_val);
      write_reg(bev_pkg::REG_REPEAT_INTERVAL, interval_val);
      in_idle_pct   = (phase == 1) ? 65 : (phase == 3) ? 20 : 0;
      out_stall_pct = (phase == 2) ? 65 : (phase == 3) ? 20 : 0;
      for (n = 0; n < TICKS_PER_PHASE; n++) begin
        // Once, the sender holds off until the block has drained.
        if (phase == 0 && n == TICKS_PER_PHASE / 2) settle_block();
        send_tick(next_mask(), 1'b0);
      end
    end

    settle_block();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
